// ===== sv/pee_pkg.sv =====
package pee_pkg;

  localparam int DATA_W = 32;
  localparam int STAT_W = 3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STAT_W-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [STAT_W-1:0] ST_INVALID   = 3'd4;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_POW
  } alu_op_t;

  // request from the controller to the arithmetic unit
  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;

endpackage

// ===== sv/prefix_expression_evaluator_unit.sv =====
// Prefix expression evaluator. Characters arrive one item each, rightmost
// first; final_char marks the leftmost, after which one result (value,
// status) is emitted and the stack and error are cleared. Operands live in
// a single-port-read stack RAM of STACK_DEPTH words. Digits and blanks are
// taken in the idle state; + and - need two RAM reads; * and / run in the
// bit-serial arithmetic unit; ^ runs there too, with one shift-add step per
// cycle. A final item goes through S_FIN and, with no error, S_FRD, which
// reads the top of the stack, to S_OUT; the result then sits in an output
// register, and a further final item waits only if that register is still
// held by the receiver.
module prefix_expression_evaluator_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         char_code,
  input  logic               final_char,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value,
  output logic [2:0]         status
);

  localparam int AW = $clog2(STACK_DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;
  pee_pkg::alu_req_t alu_req;
  pee_pkg::alu_rsp_t alu_rsp;

  pee_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  pee_alu u_alu (.clk(clk), .rst(rst), .req(alu_req), .rsp(alu_rsp));

  pee_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .char_code(char_code), .final_char(final_char),
    .out_valid(out_valid), .out_ready(out_ready),
    .value(value), .status(status),
    .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr), .mem_rdata(mem_rdata),
    .alu_req(alu_req), .alu_rsp(alu_rsp)
  );

endmodule

// ===== sv/pee_ram.sv =====
module pee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pee_alu.sv =====
// Multi-cycle multiply, divide and power unit. Multiply is shift-add,
// divide is restoring, power is square-and-multiply with shift-add steps.
module pee_alu (
  input  logic             clk,
  input  logic             rst,
  input  pee_pkg::alu_req_t req,
  output pee_pkg::alu_rsp_t rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_PMUL,
    S_PSQR,
    S_DONE
  } state_t;

  state_t        state;
  logic [31:0]   acc;      // product / quotient accumulator
  logic [31:0]   mcand;    // multiplicand
  logic [31:0]   mplier;   // multiplier bits, shifted right
  logic [31:0]   rem;
  logic [31:0]   dvd;
  logic [31:0]   dvs;
  logic          neg;
  logic [5:0]    cnt;
  logic [31:0]   pres;     // power result
  logic [31:0]   pbase;
  logic [31:0]   pexp;
  logic [31:0]   result;

  logic [32:0]   rem_sh;
  logic [32:0]   rem_sub;

  assign rem_sh  = {rem, dvd[31]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  assign rsp.done   = (state == S_DONE);
  assign rsp.result = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.start) begin
            cnt <= '0;
            case (req.op)
              pee_pkg::OP_MUL: begin
                acc    <= '0;
                mcand  <= req.a;
                mplier <= req.b;
                state  <= S_MUL;
              end
              pee_pkg::OP_DIV: begin
                neg   <= req.a[31] ^ req.b[31];
                dvd   <= req.a[31] ? (32'd0 - req.a) : req.a;
                dvs   <= req.b[31] ? (32'd0 - req.b) : req.b;
                rem   <= '0;
                acc   <= '0;
                state <= S_DIV;
              end
              default: begin
                // negative exponent handled directly
                if (req.b[31]) begin
                  if (req.a == 32'd1) begin
                    result <= 32'd1;
                  end else if (req.a == 32'hFFFF_FFFF) begin
                    result <= req.b[0] ? 32'hFFFF_FFFF : 32'd1;
                  end else begin
                    result <= '0;
                  end
                  state <= S_DONE;
                end else begin
                  pres  <= 32'd1;
                  pbase <= req.a;
                  pexp  <= req.b;
                  state <= S_PMUL;
                end
              end
            endcase
          end
        end
        S_MUL: begin
          // one multiplier bit per cycle
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          if (mplier[31:1] == '0) begin
            result <= mplier[0] ? acc + mcand : acc;
            state  <= S_DONE;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle
          dvd <= dvd << 1;
          if (!rem_sub[32]) begin
            rem <= rem_sub[31:0];
            acc <= {acc[30:0], 1'b1};
          end else begin
            rem <= rem_sh[31:0];
            acc <= {acc[30:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            result <= neg ? (32'd0 - {acc[30:0], ~rem_sub[32]})
                          : {acc[30:0], ~rem_sub[32]};
            state  <= S_DONE;
          end
        end
        S_PMUL: begin
          if (pexp == '0) begin
            result <= pres;
            state  <= S_DONE;
          end else if (pexp[0]) begin
            // pres * pbase via the shift-add loop
            acc    <= '0;
            mcand  <= pres;
            mplier <= pbase;
            state  <= S_PSQR;
            cnt    <= 6'd1;
          end else begin
            acc    <= '0;
            mcand  <= pbase;
            mplier <= pbase;
            state  <= S_PSQR;
            cnt    <= 6'd0;
          end
        end
        S_PSQR: begin
          if (mplier[31:1] == '0) begin
            if (cnt[0]) begin
              // result multiply done, now square the base
              pres   <= mplier[0] ? acc + mcand : acc;
              acc    <= '0;
              mcand  <= pbase;
              mplier <= pbase;
              cnt    <= 6'd0;
            end else begin
              pbase <= mplier[0] ? acc + mcand : acc;
              pexp  <= pexp >> 1;
              state <= S_PMUL;
            end
          end else begin
            if (mplier[0]) begin
              acc <= acc + mcand;
            end
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/pee_ctrl.sv =====
// Sequencer: reads operands from the stack memory, runs the operator,
// pushes the result and emits the final value.
module pee_ctrl #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     char_code,
  input  logic                           final_char,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             value,
  output logic [2:0]                     status,
  output logic                           mem_we,
  output logic [$clog2(STACK_DEPTH)-1:0] mem_waddr,
  output logic [31:0]                    mem_wdata,
  output logic [$clog2(STACK_DEPTH)-1:0] mem_raddr,
  input  logic [31:0]                    mem_rdata,
  output pee_pkg::alu_req_t              alu_req,
  input  pee_pkg::alu_rsp_t              alu_rsp
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_EXEC,
    S_WAIT,
    S_FIN,
    S_FRD,
    S_OUT
  } state_t;

  state_t      state;
  logic [CW-1:0] cnt;
  logic [2:0]  err;
  logic [7:0]  ch;
  logic        fin;
  logic [31:0] first;
  logic [31:0] second;
  logic [31:0] res_value;  // result waiting for the output register
  logic [2:0]  res_status;

  logic        is_digit;
  logic        is_space;
  logic        accept;
  logic        load_out;
  logic [CW-1:0] cnt_m1;

  assign is_digit = (char_code >= pee_pkg::CH_ZERO) && (char_code <= pee_pkg::CH_NINE);
  assign is_space = (char_code == pee_pkg::CH_SPACE) || (char_code == pee_pkg::CH_TAB);
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state == S_OUT) && (!out_valid || out_ready);
  assign cnt_m1   = cnt - CW'(1);

  // stack memory port control; the second operand is on the read port in S_EXEC
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt[AW-1:0];
    mem_wdata = {24'd0, char_code - pee_pkg::CH_ZERO};
    mem_raddr = cnt_m1[AW-1:0];
    if (state == S_IDLE && accept && err == pee_pkg::ST_OK && is_digit &&
        cnt < CW'(STACK_DEPTH)) begin
      mem_we = 1'b1;
    end else if (state == S_WAIT && alu_rsp.done) begin
      mem_we    = 1'b1;
      mem_wdata = alu_rsp.result;
    end else if (state == S_EXEC && ch != pee_pkg::CH_MUL && ch != pee_pkg::CH_DIV &&
                 ch != pee_pkg::CH_POW) begin
      mem_we    = (ch == pee_pkg::CH_PLUS) || (ch == pee_pkg::CH_MINUS);
      mem_wdata = (ch == pee_pkg::CH_PLUS) ? first + mem_rdata : first - mem_rdata;
    end
  end

  always_comb begin
    alu_req.start = (state == S_EXEC) &&
      ((ch == pee_pkg::CH_MUL) || (ch == pee_pkg::CH_POW) ||
       (ch == pee_pkg::CH_DIV && mem_rdata != '0));
    alu_req.op = (ch == pee_pkg::CH_MUL) ? pee_pkg::OP_MUL :
                 (ch == pee_pkg::CH_DIV) ? pee_pkg::OP_DIV : pee_pkg::OP_POW;
    alu_req.a  = first;
    alu_req.b  = mem_rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      err       <= pee_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      // output register
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            ch  <= char_code;
            fin <= final_char;
            if (err != pee_pkg::ST_OK || is_space) begin
              state <= final_char ? S_FIN : S_IDLE;
            end else if (is_digit) begin
              if (cnt < CW'(STACK_DEPTH)) begin
                cnt <= cnt + CW'(1);
              end else begin
                err <= pee_pkg::ST_OVERFLOW;
              end
              state <= final_char ? S_FIN : S_IDLE;
            end else if (cnt < CW'(2)) begin
              err   <= pee_pkg::ST_UNDERFLOW;
              cnt   <= '0;
              state <= final_char ? S_FIN : S_IDLE;
            end else begin
              state <= S_RD1;
            end
          end
        end
        S_RD1: begin
          // top read issued at cnt-1
          cnt   <= cnt_m1;
          state <= S_RD2;
        end
        S_RD2: begin
          first <= mem_rdata;
          cnt   <= cnt_m1;
          state <= S_EXEC;
        end
        S_EXEC: begin
          second <= mem_rdata;
          state  <= S_WAIT;
        end
        S_WAIT: begin
          if (ch == pee_pkg::CH_PLUS || ch == pee_pkg::CH_MINUS) begin
            cnt   <= cnt + CW'(1);
            state <= fin ? S_FIN : S_IDLE;
          end else if (ch == pee_pkg::CH_DIV && second == '0) begin
            err   <= pee_pkg::ST_DIVZERO;
            state <= fin ? S_FIN : S_IDLE;
          end else if (ch == pee_pkg::CH_MUL || ch == pee_pkg::CH_DIV ||
                       ch == pee_pkg::CH_POW) begin
            if (alu_rsp.done) begin
              cnt   <= cnt + CW'(1);
              state <= fin ? S_FIN : S_IDLE;
            end
          end else begin
            err   <= pee_pkg::ST_INVALID;
            state <= fin ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          if (err != pee_pkg::ST_OK || cnt == '0) begin
            res_value  <= '0;
            res_status <= (err != pee_pkg::ST_OK) ? err : pee_pkg::ST_UNDERFLOW;
            state      <= S_OUT;
          end else begin
            state <= S_FRD;
          end
        end
        S_FRD: begin
          state      <= S_OUT;
          res_value  <= mem_rdata;
          res_status <= pee_pkg::ST_OK;
        end
        S_OUT: begin
          if (load_out) begin
            value  <= res_value;
            status <= res_status;
            cnt    <= '0;
            err    <= pee_pkg::ST_OK;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/pee_checker.sv =====
module pee_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        final_char,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] value,
  input logic [2:0]  status
);

  // a valid result always carries a defined status code
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= pee_pkg::ST_INVALID)) else $error("bad status");

  // an error result carries value zero
  a_errval: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != pee_pkg::ST_OK |-> value == 32'd0) else $error("error value");

  // a pending result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status))
    else $error("result dropped");

  // a non-final item gives no result in the next cycle
  a_nofin: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !final_char && !out_valid |=> !out_valid)
    else $error("spurious result");

endmodule

bind prefix_expression_evaluator_unit pee_checker u_chk (.*);

// ===== bench/tb_prefix_expression_evaluator_unit.sv =====
`timescale 1ns / 100ps

module tb_prefix_expression_evaluator_unit;

  localparam int DEPTH = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [7:0] char_code = 8'h00;
  logic final_char = 1'b0;
  logic out_ready = 1'b0;
  wire in_ready;
  wire out_valid;
  wire signed [31:0] value;
  wire [2:0] status;

  typedef struct {
    logic [31:0] v;
    logic [2:0]  s;
  } result_t;

  typedef struct {
    logic [7:0]  c;
    bit          f;
    bit          typed;
    logic [31:0] v;
    logic [2:0]  s;
  } row_t;

  // predictor state
  logic [31:0] opstack [DEPTH];
  int unsigned depth_cnt = 0;
  logic [2:0]  sticky_err = pee_pkg::ST_OK;

  result_t expected_q[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  bit hold_done = 1'b0;
  bit no_idle = 1'b0;

  prefix_expression_evaluator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .char_code(char_code), .final_char(final_char),
    .out_valid(out_valid), .out_ready(out_ready),
    .value(value), .status(status)
  );

  always #5 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic logic [31:0] int_pow(logic [31:0] b, logic [31:0] e);
    logic [31:0] r = 32'd1;
    if (e[31]) begin
      if (b == 32'd1) return 32'd1;
      if (b == 32'hFFFF_FFFF) return e[0] ? 32'hFFFF_FFFF : 32'd1;
      return 32'd0;
    end
    while (e != 0) begin
      if (e[0]) r = r * b;
      b = b * b;
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma = a[31] ? -a : a;
    logic [31:0] mb = b[31] ? -b : b;
    logic [31:0] q;
    q = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic void stack_push(logic [31:0] v);
    if (depth_cnt >= DEPTH) begin
      sticky_err = pee_pkg::ST_OVERFLOW;
      return;
    end
    opstack[depth_cnt] = v;
    depth_cnt++;
  endfunction

  function automatic logic [31:0] stack_pop();
    if (depth_cnt == 0) begin
      sticky_err = pee_pkg::ST_UNDERFLOW;
      return 32'd0;
    end
    depth_cnt--;
    return opstack[depth_cnt];
  endfunction

  function automatic void eval_char(logic [7:0] c);
    logic [31:0] first, second, r;
    if (c >= pee_pkg::CH_ZERO && c <= pee_pkg::CH_NINE) begin
      stack_push({24'd0, c - pee_pkg::CH_ZERO});
      return;
    end
    if (c == pee_pkg::CH_SPACE || c == pee_pkg::CH_TAB) return;
    first = stack_pop();
    if (sticky_err != pee_pkg::ST_OK) return;
    second = stack_pop();
    if (sticky_err != pee_pkg::ST_OK) return;
    case (c)
      pee_pkg::CH_PLUS:  r = first + second;
      pee_pkg::CH_MINUS: r = first - second;
      pee_pkg::CH_MUL:   r = first * second;
      pee_pkg::CH_DIV: begin
        if (second == 0) begin
          sticky_err = pee_pkg::ST_DIVZERO;
          return;
        end
        r = trunc_div(first, second);
      end
      pee_pkg::CH_POW:   r = int_pow(first, second);
      default: begin
        sticky_err = pee_pkg::ST_INVALID;
        return;
      end
    endcase
    stack_push(r);
  endfunction

  // returns 1 when the item produces a result
  function automatic bit predict_item(logic [7:0] c, bit fin, output result_t r);
    logic [31:0] v = 32'd0;
    if (sticky_err == pee_pkg::ST_OK) eval_char(c);
    if (!fin) return 1'b0;
    if (sticky_err == pee_pkg::ST_OK) v = stack_pop();
    if (sticky_err != pee_pkg::ST_OK) v = 32'd0;
    r.v = v;
    r.s = sticky_err;
    depth_cnt = 0;
    sticky_err = pee_pkg::ST_OK;
    return 1'b1;
  endfunction

  // ---------------- sender ----------------
  task automatic send_item(logic [7:0] c, bit fin, bit typed = 1'b0,
                           logic [31:0] tv = 0, logic [2:0] ts = pee_pkg::ST_OK);
    int gap;
    result_t r;
    gap = 0;
    if (!no_idle) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap = 0;
        9:          gap = $urandom_range(5, 40);
        default:    gap = $urandom_range(1, 3);
      endcase
    end
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    char_code  <= c;
    final_char <= fin;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (predict_item(c, fin, r)) begin
      if (typed) begin
        r.v = tv;
        r.s = ts;
      end
      expected_q.push_back(r);
    end
  endtask

  task automatic send_expression();
    int kind, ops, pushes, d, n, i;
    bit do_op;
    logic [7:0] c;
    logic [7:0] seq[$];
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      // well-formed: fed rightmost first, so this is operand-first order
      ops = $urandom_range(0, 7);
      pushes = ops + 1;
      d = 0;
      while (pushes + ops > 0) begin
        do_op = (d >= 2 && ops > 0) && (pushes == 0 || $urandom_range(0, 1));
        if (do_op) begin
          case ($urandom_range(0, 9))
            0, 1:    c = pee_pkg::CH_PLUS;
            2, 3:    c = pee_pkg::CH_MINUS;
            4, 5:    c = pee_pkg::CH_MUL;
            6, 7:    c = pee_pkg::CH_DIV;
            default: c = pee_pkg::CH_POW;
          endcase
          ops--;
          d--;
        end else begin
          c = pee_pkg::CH_ZERO + 8'($urandom_range(0, 9));
          pushes--;
          d++;
        end
        seq.push_back(c);
        if ($urandom_range(0, 9) == 0)
          seq.push_back($urandom_range(0, 1) ? pee_pkg::CH_SPACE : pee_pkg::CH_TAB);
      end
    end else if (kind < 92) begin
      // noise: arbitrary bytes
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) seq.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 95) begin
      // fill the stack to about the brim, from one short to two past
      n = $urandom_range(DEPTH - 1, DEPTH + 2);
      for (i = 0; i < n; i++) seq.push_back(pee_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end else begin
      // broken: operator short of operands
      n = $urandom_range(0, 1);
      for (i = 0; i < n; i++) seq.push_back(pee_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      seq.push_back(pee_pkg::CH_PLUS);
      seq.push_back(pee_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
    for (i = 0; i < seq.size(); i++) send_item(seq[i], i == seq.size() - 1);
  endtask

  // directed items
  row_t dir_rows [24] = '{
    '{pee_pkg::CH_NINE,  1, 1, 32'd9, pee_pkg::ST_OK},
    '{pee_pkg::CH_ZERO,  1, 1, 32'd0, pee_pkg::ST_OK},
    '{pee_pkg::CH_SPACE, 1, 1, 32'd0, pee_pkg::ST_UNDERFLOW},
    '{8'h33,             0, 0, 0, pee_pkg::ST_OK},
    '{8'h34,             0, 0, 0, pee_pkg::ST_OK},
    '{pee_pkg::CH_PLUS,  1, 0, 0, pee_pkg::ST_OK},
    '{8'h35,             0, 0, 0, pee_pkg::ST_OK},
    '{pee_pkg::CH_ZERO,  0, 0, 0, pee_pkg::ST_OK},
    '{pee_pkg::CH_MINUS, 1, 0, 0, pee_pkg::ST_OK},
    '{8'h32,             0, 0, 0, pee_pkg::ST_OK},
    '{pee_pkg::CH_NINE,  0, 0, 0, pee_pkg::ST_OK},
    '{pee_pkg::CH_DIV,   1, 0, 0, pee_pkg::ST_OK},
    '{pee_pkg::CH_ZERO,  0, 0, 0, pee_pkg::ST_OK},
    '{8'h35,             0, 0, 0, pee_pkg::ST_OK},
    '{pee_pkg::CH_DIV,   1, 1, 32'd0, pee_pkg::ST_DIVZERO},
    '{8'h33,             0, 0, 0, pee_pkg::ST_OK},
    '{8'h32,             0, 0, 0, pee_pkg::ST_OK},
    '{pee_pkg::CH_POW,   1, 0, 0, pee_pkg::ST_OK},
    '{8'h31,             0, 0, 0, pee_pkg::ST_OK},
    '{pee_pkg::CH_PLUS,  1, 1, 32'd0, pee_pkg::ST_UNDERFLOW},
    '{8'h32,             0, 0, 0, pee_pkg::ST_OK},
    '{8'h33,             0, 0, 0, pee_pkg::ST_OK},
    '{8'hFF,             0, 0, 0, pee_pkg::ST_OK},
    '{pee_pkg::CH_MUL,   1, 1, 32'd0, pee_pkg::ST_INVALID}
  };

  // ---------------- main stimulus ----------------
  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < $size(dir_rows); i++)
      send_item(dir_rows[i].c, dir_rows[i].f, dir_rows[i].typed, dir_rows[i].v,
                dir_rows[i].s);
    while (items_sent < 650) begin
      if ($urandom_range(0, 9) == 0) no_idle = !no_idle;
      send_expression();
    end
    @(negedge clk) in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk);
    $display("Sent %0d items, checked %0d results (digits, blanks, all operators, errors).",
             items_sent, results_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------- receiver ----------------
  initial begin
    forever begin
      @(negedge clk);
      if (!hold_done && items_sent >= 300) begin
        // long hold-off so the block backs up and stalls its input
        out_ready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_done = 1'b1;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 9) < 7);
      end
    end
  end

  // ---------------- result check ----------------
  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result value=%0d status=%0d", $time, value, status);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (value !== e.v) begin
          $display("%0t: value mismatch expected %0d actual %0d",
                   $time, $signed(e.v), value);
          errors++;
        end
        if (status !== e.s) begin
          $display("%0t: status mismatch expected %0d actual %0d", $time, e.s, status);
          errors++;
        end
      end
    end
  end

  // ---------------- timeout ----------------
  initial begin
    #50_000_000;
    $display("Timeout with %0d results outstanding", expected_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
